/* rtl/olt_pkg.sv */
// ---------------------------------------------------------------------------
// olt_pkg: shared definitions for the order lifecycle tracker
// Codes, table entry layouts and lifecycle helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package olt_pkg;

  localparam int ORDER_SLOTS_DEF = 64;
  localparam int MAP_SLOTS_DEF   = 64;

  // Request actions.
  localparam logic [1:0] ACT_PLACE   = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_UPDATE  = 2'd3;

  // Order status codes; zero is both "unknown" on input and "pending" in the table.
  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_PARTIAL  = 3'd2;
  localparam logic [2:0] ST_FILLED   = 3'd3;
  localparam logic [2:0] ST_CANCELED = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;
  localparam logic [2:0] ST_REPLACED = 3'd6;
  localparam logic [2:0] ST_INVALID  = 3'd7;

  localparam logic [1:0] SIDE_UNKNOWN = 2'd0;

  // Error codes.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_MISSING_ID  = 4'd1;
  localparam logic [3:0] ERR_DUPLICATE   = 4'd2;
  localparam logic [3:0] ERR_UNKNOWN_XCH = 4'd3;
  localparam logic [3:0] ERR_MISMATCH    = 4'd4;
  localparam logic [3:0] ERR_NO_TARGET   = 4'd5;
  localparam logic [3:0] ERR_UNTRACKED   = 4'd6;
  localparam logic [3:0] ERR_TERMINAL    = 4'd7;
  localparam logic [3:0] ERR_REPL_SAME   = 4'd8;
  localparam logic [3:0] ERR_REPL_EXISTS = 4'd9;
  localparam logic [3:0] ERR_MARKET      = 4'd10;
  localparam logic [3:0] ERR_BAD_STATUS  = 4'd11;
  localparam logic [3:0] ERR_UNKNOWN_ORD = 4'd12;
  localparam logic [3:0] ERR_TRANSITION  = 4'd13;
  localparam logic [3:0] ERR_FULL        = 4'd14;

  // Event counter indexes.
  localparam int EVT_POLICY    = 0;
  localparam int EVT_APPLIED   = 1;
  localparam int EVT_BAD_TRANS = 2;
  localparam int EVT_UNKNOWN   = 3;
  localparam int EVT_FULL      = 4;
  localparam int EVT_COUNT     = 5;

  typedef struct packed {
    logic [31:0] client;
    logic [31:0] exchange;
    logic [31:0] ticker;
    logic [1:0]  side;
    logic [2:0]  state;
    logic [30:0] requested;
    logic [30:0] filled;
    logic [63:0] created;
    logic [63:0] updated;
    logic [31:0] tag;
    logic [31:0] replaces;
  } ord_ent_t;

  typedef struct packed {
    logic [31:0] exchange;
    logic [31:0] client;
  } map_ent_t;

  function automatic logic status_final(input logic [2:0] s);
    return (s == ST_FILLED) || (s == ST_CANCELED) || (s == ST_REJECTED);
  endfunction

  function automatic logic move_allowed(input logic [2:0] cur, input logic [2:0] nxt);
    logic ok;
    ok = 1'b0;
    if (cur == nxt) begin
      ok = 1'b1;
    end else begin
      case (cur)
        ST_PENDING:  ok = nxt inside {[ST_ACCEPTED:ST_REJECTED]};
        ST_ACCEPTED: ok = nxt inside {[ST_PARTIAL:ST_REPLACED]};
        ST_PARTIAL:  ok = nxt inside {[ST_FILLED:ST_REPLACED]};
        ST_REPLACED: ok = nxt inside {[ST_ACCEPTED:ST_REJECTED]};
        default:     ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/olt_if.sv */
// ---------------------------------------------------------------------------
// olt_if: request and result channels of the order lifecycle tracker
// Valid/ready channels; a request or result moves when both are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface olt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] request_tag;
  logic [31:0] client_id;
  logic [31:0] target_client_id;
  logic [31:0] exchange_id;
  logic [31:0] ticker_code;
  logic [1:0]  side_code;
  logic [30:0] quantity;
  logic [63:0] time_ns;
  logic [2:0]  new_status;
  logic        has_fill;

  modport source (output valid, action, request_tag, client_id, target_client_id,
                  exchange_id, ticker_code, side_code, quantity, time_ns,
                  new_status, has_fill, input ready);
  modport sink (input valid, action, request_tag, client_id, target_client_id,
                exchange_id, ticker_code, side_code, quantity, time_ns,
                new_status, has_fill, output ready);
endinterface

interface olt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [3:0]  error_code;
  logic [2:0]  order_status;
  logic [30:0] filled_lots;
  logic [1:0]  fill_side;
  logic [6:0]  tracked_count;
  logic [6:0]  live_count;

  modport source (output valid, ok, error_code, order_status, filled_lots,
                  fill_side, tracked_count, live_count, input ready);
  modport sink (input valid, ok, error_code, order_status, filled_lots,
                fill_side, tracked_count, live_count, output ready);
endinterface

`default_nettype wire

/* rtl/order_lifecycle_tracker.sv */
// ---------------------------------------------------------------------------
// order_lifecycle_tracker: order table with exchange-id map and policy checks
// Handles place, cancel, replace and status update requests, one at a time.
// ---------------------------------------------------------------------------
// One request is in work at a time. After acceptance the block sweeps the
// exchange map (only when the request carries a nonzero exchange id) and then
// the order table, one entry per cycle through the single read port of each
// memory, then reads the affected entry and writes it back. A request rejected
// on its first checks (missing client id, bad update status) skips both sweeps
// and goes straight to execution. The sweep lengths over the filled part
// of each memory set the rate. Entries are allocated in ascending slot order
// and never removed, so a fill count per memory stands in for valid bits
// and no clearing pass is needed after reset. The finished result sits in an
// output register, and the next request may be taken while it waits.
`default_nettype none

module order_lifecycle_tracker #(
  parameter int ORDER_SLOTS = olt_pkg::ORDER_SLOTS_DEF,
  parameter int MAP_SLOTS   = olt_pkg::MAP_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olt_in_if.sink      in_chan,
  olt_out_if.source   out_chan
);

  localparam int OAW = $clog2(ORDER_SLOTS);
  localparam int OCW = $clog2(ORDER_SLOTS + 1);
  localparam int MAW = $clog2(MAP_SLOTS);
  localparam int MCW = $clog2(MAP_SLOTS + 1);
  localparam logic [OCW-1:0] OFULL = OCW'(ORDER_SLOTS);
  localparam logic [MCW-1:0] MFULL = MCW'(MAP_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_ORD  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  // Memories: order table and exchange map, registered reads.
  olt_pkg::ord_ent_t ord_mem [ORDER_SLOTS];
  olt_pkg::map_ent_t map_mem [MAP_SLOTS];
  olt_pkg::ord_ent_t ent_q;
  olt_pkg::map_ent_t map_q;
  logic [OAW-1:0]    ord_raddr;
  logic [MAW-1:0]    map_raddr;
  logic              ord_we;
  logic [OAW-1:0]    ord_waddr;
  olt_pkg::ord_ent_t ord_wdata;
  logic              map_we;
  logic [MAW-1:0]    map_waddr;
  olt_pkg::map_ent_t map_wdata;

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ent_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  // Control state.
  logic [2:0]     state_r, state_nxt;
  logic [OCW-1:0] ord_cnt_r;
  logic [OCW-1:0] act_cnt_r;
  logic [MCW-1:0] map_cnt_r;
  logic [31:0]    evt_cnt_r [olt_pkg::EVT_COUNT];
  logic           out_valid_r;

  // Sweep bookkeeping: idx_r is the address issued, cidx_r the one compared.
  logic [OCW-1:0] oidx_r;
  logic [MCW-1:0] midx_r;
  logic           chk_r;
  logic [OAW-1:0] ocidx_r;
  logic [MAW-1:0] mcidx_r;

  // Latched request.
  logic [1:0]  act_r;
  logic [31:0] tag_r, cid_r, tcid_r, xid_r, tick_r;
  logic [1:0]  side_r;
  logic [30:0] qty_r;
  logic [63:0] time_r;
  logic [2:0]  nst_r;
  logic        fill_r;

  // Lookup results.
  logic           map_hit_r;
  logic [MAW-1:0] m_r;
  logic [31:0]    byx_r;
  logic           hit_c_r, hit_t_r, hit_x_r;
  logic [OAW-1:0] k_c_r, k_t_r, k_x_r;
  logic [OAW-1:0] tk_r;
  logic [31:0]    tgt_r;
  logic [3:0]     pre_err_r;

  // Output payload registers.
  logic        o_ok_r;
  logic [3:0]  o_err_r;
  logic [2:0]  o_status_r;
  logic [30:0] o_filled_r;
  logic [1:0]  o_fside_r;
  logic [6:0]  o_tracked_r;
  logic [6:0]  o_active_r;

  logic accept;
  logic fire;
  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign fire          = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  // Resolution after both sweeps: target entry and sweep-based errors.
  logic [3:0]     res_err;
  logic [OAW-1:0] res_tk;
  logic [31:0]    res_tgt;
  logic           have_c;
  logic [31:0]    by_c;
  logic           by_c_hit;
  logic [OAW-1:0] by_c_k;

  always_comb begin
    res_err  = olt_pkg::ERR_NONE;
    res_tk   = k_c_r;
    res_tgt  = cid_r;
    have_c   = (tcid_r != 32'd0) || (act_r == olt_pkg::ACT_CANCEL);
    by_c     = (tcid_r != 32'd0) ? tcid_r : cid_r;
    by_c_hit = (tcid_r != 32'd0) ? hit_t_r : hit_c_r;
    by_c_k   = (tcid_r != 32'd0) ? k_t_r : k_c_r;
    case (act_r)
      olt_pkg::ACT_UPDATE: begin
        if (hit_c_r) begin
          res_tk = k_c_r;
        end else if (xid_r != 32'd0 && map_hit_r && hit_x_r) begin
          res_tk = k_x_r;
        end else begin
          res_err = olt_pkg::ERR_UNKNOWN_ORD;
        end
      end
      olt_pkg::ACT_PLACE: begin
        res_tk = k_c_r;
      end
      default: begin
        // Cancel and replace resolve a target by client id and/or exchange id.
        if (xid_r != 32'd0 && !map_hit_r) begin
          res_err = olt_pkg::ERR_UNKNOWN_XCH;
        end else if (have_c && xid_r != 32'd0 && by_c != byx_r) begin
          res_err = olt_pkg::ERR_MISMATCH;
        end else if (have_c) begin
          res_tgt = by_c;
          res_tk  = by_c_k;
          if (!by_c_hit) begin
            res_err = olt_pkg::ERR_UNTRACKED;
          end
        end else if (xid_r != 32'd0) begin
          res_tgt = byx_r;
          res_tk  = k_x_r;
          if (!hit_x_r) begin
            res_err = olt_pkg::ERR_UNTRACKED;
          end
        end else begin
          res_err = olt_pkg::ERR_NO_TARGET;
        end
      end
    endcase
  end

  // Read address selection.
  always_comb begin
    map_raddr = midx_r[MAW-1:0];
    ord_raddr = tk_r;
    if (state_r == S_ORD) begin
      ord_raddr = oidx_r[OAW-1:0];
    end else if (state_r == S_RES) begin
      ord_raddr = res_tk;
    end
  end

  // Execution: final checks on the read entry, then the write-back.
  logic [3:0]  err;
  logic [2:0]  x_status;
  logic [30:0] x_filled;
  logic [1:0]  x_fside;
  logic [1:0]  fs;
  logic        act_add, act_sub, ocnt_inc, mcnt_inc;

  always_comb begin
    err       = pre_err_r;
    x_status  = olt_pkg::ST_PENDING;
    x_filled  = 31'd0;
    x_fside   = olt_pkg::SIDE_UNKNOWN;
    fs        = side_r;
    act_add   = 1'b0;
    act_sub   = 1'b0;
    ocnt_inc  = 1'b0;
    mcnt_inc  = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = tk_r;
    ord_wdata = ent_q;
    map_we    = 1'b0;
    map_waddr = map_hit_r ? m_r : map_cnt_r[MAW-1:0];
    map_wdata.exchange = xid_r;
    map_wdata.client   = ent_q.client;
    if (pre_err_r == olt_pkg::ERR_NONE) begin
      case (act_r)
        olt_pkg::ACT_UPDATE: begin
          if (!olt_pkg::move_allowed(ent_q.state, nst_r)) begin
            err = olt_pkg::ERR_TRANSITION;
          end else if (xid_r != 32'd0 && !map_hit_r && map_cnt_r == MFULL) begin
            err = olt_pkg::ERR_FULL;
          end else begin
            ord_we            = 1'b1;
            ord_wdata.state   = nst_r;
            ord_wdata.updated = time_r;
            if (tick_r != 32'd0) begin
              ord_wdata.ticker = tick_r;
            end
            if (xid_r != 32'd0) begin
              ord_wdata.exchange = xid_r;
              map_we             = 1'b1;
              mcnt_inc           = !map_hit_r;
            end
            if (fill_r) begin
              if (fs == olt_pkg::SIDE_UNKNOWN && ent_q.side != olt_pkg::SIDE_UNKNOWN) begin
                fs = ent_q.side;
              end
              if (ent_q.side == olt_pkg::SIDE_UNKNOWN && fs != olt_pkg::SIDE_UNKNOWN) begin
                ord_wdata.side = fs;
              end
              if (nst_r == olt_pkg::ST_FILLED && ent_q.requested != 31'd0) begin
                ord_wdata.filled = ent_q.requested;
              end else if (qty_r > ent_q.filled) begin
                ord_wdata.filled = qty_r;
              end
              x_fside = fs;
            end
            x_status = nst_r;
            x_filled = ord_wdata.filled;
            act_add  = olt_pkg::status_final(ent_q.state) && !olt_pkg::status_final(nst_r);
            act_sub  = !olt_pkg::status_final(ent_q.state) && olt_pkg::status_final(nst_r);
          end
        end
        olt_pkg::ACT_CANCEL: begin
          if (olt_pkg::status_final(ent_q.state)) begin
            err = olt_pkg::ERR_TERMINAL;
          end else begin
            x_status = ent_q.state;
            x_filled = ent_q.filled;
          end
        end
        olt_pkg::ACT_REPLACE: begin
          if (olt_pkg::status_final(ent_q.state)) begin
            err = olt_pkg::ERR_TERMINAL;
          end else if (tgt_r == cid_r) begin
            err = olt_pkg::ERR_REPL_SAME;
          end else if (hit_c_r) begin
            err = olt_pkg::ERR_REPL_EXISTS;
          end else if (tick_r != 32'd0 && ent_q.ticker != 32'd0 && tick_r != ent_q.ticker) begin
            err = olt_pkg::ERR_MARKET;
          end else if (ord_cnt_r == OFULL) begin
            err = olt_pkg::ERR_FULL;
          end else begin
            ord_we              = 1'b1;
            ord_waddr           = ord_cnt_r[OAW-1:0];
            ord_wdata.client    = cid_r;
            ord_wdata.exchange  = 32'd0;
            ord_wdata.ticker    = (tick_r != 32'd0) ? tick_r : ent_q.ticker;
            ord_wdata.side      = (side_r != olt_pkg::SIDE_UNKNOWN) ? side_r : ent_q.side;
            ord_wdata.state     = olt_pkg::ST_PENDING;
            ord_wdata.requested = (qty_r != 31'd0) ? qty_r : ent_q.requested;
            ord_wdata.filled    = 31'd0;
            ord_wdata.created   = time_r;
            ord_wdata.updated   = 64'd0;
            ord_wdata.tag       = tag_r;
            ord_wdata.replaces  = tgt_r;
            ocnt_inc            = 1'b1;
            act_add             = 1'b1;
          end
        end
        default: begin
          // Place.
          if (hit_c_r) begin
            err = olt_pkg::ERR_DUPLICATE;
          end else if (ord_cnt_r == OFULL) begin
            err = olt_pkg::ERR_FULL;
          end else begin
            ord_we              = 1'b1;
            ord_waddr           = ord_cnt_r[OAW-1:0];
            ord_wdata.client    = cid_r;
            ord_wdata.exchange  = 32'd0;
            ord_wdata.ticker    = tick_r;
            ord_wdata.side      = side_r;
            ord_wdata.state     = olt_pkg::ST_PENDING;
            ord_wdata.requested = qty_r;
            ord_wdata.filled    = 31'd0;
            ord_wdata.created   = time_r;
            ord_wdata.updated   = 64'd0;
            ord_wdata.tag       = tag_r;
            ord_wdata.replaces  = 32'd0;
            ocnt_inc            = 1'b1;
            act_add             = 1'b1;
          end
        end
      endcase
    end
    // Nothing is committed until the output register can take the result.
    if (!fire) begin
      ord_we = 1'b0;
      map_we = 1'b0;
    end
  end

  logic [OCW-1:0] ord_cnt_nxt, act_cnt_nxt;
  assign ord_cnt_nxt = ocnt_inc ? ord_cnt_r + OCW'(1) : ord_cnt_r;
  assign act_cnt_nxt = act_add ? act_cnt_r + OCW'(1) :
                       act_sub ? act_cnt_r - OCW'(1) : act_cnt_r;

  // Which event counter this request bumps, if any.
  logic       evt_en;
  logic [2:0] evt_sel;
  always_comb begin
    evt_en  = 1'b1;
    evt_sel = 3'(olt_pkg::EVT_POLICY);
    case (err) inside
      olt_pkg::ERR_NONE: begin
        evt_en  = (act_r == olt_pkg::ACT_UPDATE);
        evt_sel = 3'(olt_pkg::EVT_APPLIED);
      end
      olt_pkg::ERR_BAD_STATUS, olt_pkg::ERR_TRANSITION: evt_sel = 3'(olt_pkg::EVT_BAD_TRANS);
      olt_pkg::ERR_UNKNOWN_ORD: evt_sel = 3'(olt_pkg::EVT_UNKNOWN);
      olt_pkg::ERR_FULL:        evt_sel = 3'(olt_pkg::EVT_FULL);
      default:                  evt_sel = 3'(olt_pkg::EVT_POLICY);
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.action == olt_pkg::ACT_UPDATE &&
              (in_chan.new_status == olt_pkg::ST_PENDING ||
               in_chan.new_status == olt_pkg::ST_INVALID)) begin
            state_nxt = S_EXEC;
          end else if (in_chan.action != olt_pkg::ACT_UPDATE && in_chan.client_id == 32'd0) begin
            state_nxt = S_EXEC;
          end else if (in_chan.exchange_id != 32'd0) begin
            state_nxt = S_MAP;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_MAP:   if (!chk_r && midx_r == map_cnt_r) state_nxt = S_ORD;
      S_ORD:   if (!chk_r && oidx_r == ord_cnt_r) state_nxt = S_RES;
      S_RES:   state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ord_cnt_r   <= '0;
      act_cnt_r   <= '0;
      map_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
      for (int i = 0; i < olt_pkg::EVT_COUNT; i++) begin
        evt_cnt_r[i] <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      // A new result may load in the same cycle the old one leaves.
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          chk_r <= 1'b0;
          if (accept) begin
            midx_r <= '0;
            oidx_r <= '0;
          end
        end
        S_MAP: begin
          if (midx_r != map_cnt_r) begin
            midx_r  <= midx_r + MCW'(1);
            mcidx_r <= midx_r[MAW-1:0];
            chk_r   <= 1'b1;
          end else begin
            chk_r <= 1'b0;
          end
          if (state_nxt == S_ORD) begin
            oidx_r <= '0;
          end
        end
        S_ORD: begin
          if (oidx_r != ord_cnt_r) begin
            oidx_r  <= oidx_r + OCW'(1);
            ocidx_r <= oidx_r[OAW-1:0];
            chk_r   <= 1'b1;
          end else begin
            chk_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (fire) begin
            ord_cnt_r <= ord_cnt_nxt;
            act_cnt_r <= act_cnt_nxt;
            if (mcnt_inc) begin
              map_cnt_r <= map_cnt_r + MCW'(1);
            end
            if (evt_en) begin
              evt_cnt_r[evt_sel] <= evt_cnt_r[evt_sel] + 32'd1;
            end
          end
        end
        default: begin
          chk_r <= 1'b0;
        end
      endcase
    end
  end

  // Request latch, lookup results and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_chan.action;
      tag_r     <= in_chan.request_tag;
      cid_r     <= in_chan.client_id;
      tcid_r    <= in_chan.target_client_id;
      xid_r     <= in_chan.exchange_id;
      tick_r    <= in_chan.ticker_code;
      side_r    <= in_chan.side_code;
      qty_r     <= in_chan.quantity;
      time_r    <= in_chan.time_ns;
      nst_r     <= in_chan.new_status;
      fill_r    <= in_chan.has_fill;
      map_hit_r <= 1'b0;
      hit_c_r   <= 1'b0;
      hit_t_r   <= 1'b0;
      hit_x_r   <= 1'b0;
      if (in_chan.action == olt_pkg::ACT_UPDATE) begin
        pre_err_r <= (in_chan.new_status == olt_pkg::ST_PENDING ||
                      in_chan.new_status == olt_pkg::ST_INVALID) ?
                     olt_pkg::ERR_BAD_STATUS : olt_pkg::ERR_NONE;
      end else begin
        pre_err_r <= (in_chan.client_id == 32'd0) ? olt_pkg::ERR_MISSING_ID : olt_pkg::ERR_NONE;
      end
    end
    // Exchange ids in the map are unique, so the first hit is the only one.
    if (state_r == S_MAP && chk_r && !map_hit_r && map_q.exchange == xid_r) begin
      map_hit_r <= 1'b1;
      m_r       <= mcidx_r;
      byx_r     <= map_q.client;
    end
    if (state_r == S_ORD && chk_r) begin
      if (ent_q.client == cid_r) begin
        hit_c_r <= 1'b1;
        k_c_r   <= ocidx_r;
      end
      if (ent_q.client == tcid_r) begin
        hit_t_r <= 1'b1;
        k_t_r   <= ocidx_r;
      end
      if (map_hit_r && ent_q.client == byx_r) begin
        hit_x_r <= 1'b1;
        k_x_r   <= ocidx_r;
      end
    end
    if (state_r == S_RES) begin
      tk_r      <= res_tk;
      tgt_r     <= res_tgt;
      pre_err_r <= res_err;
    end
    if (fire) begin
      o_ok_r      <= (err == olt_pkg::ERR_NONE);
      o_err_r     <= err;
      o_status_r  <= (err == olt_pkg::ERR_NONE) ? x_status : olt_pkg::ST_PENDING;
      o_filled_r  <= (err == olt_pkg::ERR_NONE) ? x_filled : 31'd0;
      o_fside_r   <= (err == olt_pkg::ERR_NONE) ? x_fside : olt_pkg::SIDE_UNKNOWN;
      o_tracked_r <= 7'(ord_cnt_nxt);
      o_active_r  <= 7'(act_cnt_nxt);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = o_ok_r;
  assign out_chan.error_code    = o_err_r;
  assign out_chan.order_status  = o_status_r;
  assign out_chan.filled_lots   = o_filled_r;
  assign out_chan.fill_side     = o_fside_r;
  assign out_chan.tracked_count = o_tracked_r;
  assign out_chan.live_count    = o_active_r;

endmodule

`default_nettype wire
